### rtl/core/thm_pkg.sv
// shared types and constants of the task heartbeat monitor
`timescale 1ns / 1ps
package thm_pkg;

   localparam int DEF_NUM_TASKS = 8;
   localparam int MAX_TASKS     = 64;
   localparam int TASK_IDX_W    = 6;
   localparam int BEAT_W        = 32;
   localparam int MISS_W        = 8;
   localparam int TOTAL_W       = 32;
   localparam int QUEUE_DEPTH   = 2;

   localparam logic [MISS_W-1:0] MAX_MISSED_RST = 8'd3;
   localparam logic [MISS_W-1:0] MISS_SAT       = 8'hFF;

   // request codes on the input channel
   localparam logic [1:0] REQ_REGISTER = 2'd0;
   localparam logic [1:0] REQ_BEAT     = 2'd1;
   localparam logic [1:0] REQ_CHECK    = 2'd2;

   typedef enum logic [1:0] {
      OP_REGISTER,
      OP_BEAT,
      OP_CHECK,
      OP_NONE
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_BAD_ID = 2'd1,
      STAT_HUNG   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BEAT,
      ST_WALK,
      ST_DECIDE,
      ST_RESP
   } state_type;

   typedef struct packed {
      op_type                op;
      logic                  id_ok;
      logic [TASK_IDX_W-1:0] idx;
   } cmd_type;

   typedef struct packed {
      logic [BEAT_W-1:0] beat;
      logic [BEAT_W-1:0] seen;
      logic [MISS_W-1:0] missed;
   } rec_type;

   typedef struct packed {
      status_type             status;
      logic                   feed;
      logic [TASK_IDX_W-1:0]  hung_slot;
      logic [BEAT_W-1:0]      hung_heartbeat;
      logic [TOTAL_W-1:0]     health_checks;
      logic [TOTAL_W-1:0]     feeds_total;
      logic [TOTAL_W-1:0]     faults_total;
   } rsp_type;

endpackage

### rtl/core/thm_req_if.sv
// request channel of the task heartbeat monitor
`timescale 1ns / 1ps
interface thm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] task_id;

   modport source (output valid, req_type, task_id, input ready);
   modport sink   (input valid, req_type, task_id, output ready);
endinterface

### rtl/core/thm_rsp_if.sv
// response channel of the task heartbeat monitor
`timescale 1ns / 1ps
interface thm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic        feed;
   logic [5:0]  hung_slot;
   logic [31:0] hung_heartbeat;
   logic [31:0] health_checks;
   logic [31:0] feeds_total;
   logic [31:0] faults_total;

   modport source (output valid, status, feed, hung_slot, hung_heartbeat, health_checks,
                   feeds_total, faults_total, input ready);
   modport sink   (input valid, status, feed, hung_slot, hung_heartbeat, health_checks,
                   feeds_total, faults_total, output ready);
endinterface

### rtl/core/thm_front.sv
// front end: accepts request items and decodes them into commands
`timescale 1ns / 1ps
module thm_front #(
   parameter int NUM_TASKS = thm_pkg::DEF_NUM_TASKS
) (
   thm_req_if.sink          req_chan,
   input  logic             q_full,
   output logic             q_push,
   output thm_pkg::cmd_type q_item
);

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;

   always_comb begin
      case (req_chan.req_type)
         thm_pkg::REQ_REGISTER: q_item.op = thm_pkg::OP_REGISTER;
         thm_pkg::REQ_BEAT:     q_item.op = thm_pkg::OP_BEAT;
         thm_pkg::REQ_CHECK:    q_item.op = thm_pkg::OP_CHECK;
         default:               q_item.op = thm_pkg::OP_NONE;
      endcase
      q_item.id_ok = req_chan.task_id < 8'(NUM_TASKS);
      q_item.idx   = req_chan.task_id[thm_pkg::TASK_IDX_W-1:0];
   end

endmodule

### rtl/core/thm_queue.sv
// short command queue between front end and sequencer
`timescale 1ns / 1ps
module thm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  thm_pkg::cmd_type push_item,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output thm_pkg::cmd_type head_item
);

   localparam int PTR_W = (thm_pkg::QUEUE_DEPTH > 1) ? $clog2(thm_pkg::QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(thm_pkg::QUEUE_DEPTH + 1);

   thm_pkg::cmd_type slot_ff [thm_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full       = count_ff == CNT_W'(thm_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_item  = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(thm_pkg::QUEUE_DEPTH - 1)) return '0;
      return p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) count_in = count_ff + CNT_W'(1);
      if (do_pop && !do_push) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule

### rtl/core/thm_back.sv
// sequencer: executes commands against the per-task table and drives responses
`timescale 1ns / 1ps
module thm_back #(
   parameter int NUM_TASKS = thm_pkg::DEF_NUM_TASKS
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [thm_pkg::MISS_W-1:0] max_missed,
   input  logic                       q_valid,
   input  thm_pkg::cmd_type           q_item,
   output logic                       q_pop,
   thm_rsp_if.source                  rsp_chan
);

   localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

   thm_pkg::state_type state_ff, state_in;
   thm_pkg::cmd_type   cur_ff, cur_in;
   logic [IDX_W-1:0]   walk_ff, walk_in;
   logic               hung_found_ff, hung_found_in;
   logic [IDX_W-1:0]   hung_idx_ff, hung_idx_in;
   logic [thm_pkg::BEAT_W-1:0]  hung_beat_ff, hung_beat_in;
   thm_pkg::status_type         res_status_ff, res_status_in;
   logic [thm_pkg::TOTAL_W-1:0] check_total_ff, check_total_in;
   logic [thm_pkg::TOTAL_W-1:0] feed_total_ff, feed_total_in;
   logic [thm_pkg::TOTAL_W-1:0] fault_total_ff, fault_total_in;
   logic [NUM_TASKS-1:0] reg_ff, reg_in;
   logic [NUM_TASKS-1:0] live_ff, live_in;
   logic                 out_valid_ff, out_valid_in;
   thm_pkg::rsp_type     out_data_ff, out_data_in;

   // per-task table
   thm_pkg::rec_type mem [NUM_TASKS];
   thm_pkg::rec_type rd_data_ff;
   logic             rd_live_ff;
   logic             mem_we;
   logic [IDX_W-1:0] mem_waddr, mem_raddr;
   thm_pkg::rec_type mem_wdata;

   thm_pkg::rec_type           rec_cur;
   logic                       beat_same;
   logic [thm_pkg::MISS_W-1:0] miss_next;
   logic                       walk_last;
   logic                       out_free;
   logic [IDX_W-1:0]           cur_idx;

   // an entry never written since reset reads as zero
   assign rec_cur   = rd_live_ff ? rd_data_ff : '0;
   assign beat_same = rec_cur.beat == rec_cur.seen;
   assign miss_next = !beat_same ? '0 :
                      (rec_cur.missed == thm_pkg::MISS_SAT) ? rec_cur.missed :
                      rec_cur.missed + thm_pkg::MISS_W'(1);
   assign walk_last = walk_ff == IDX_W'(NUM_TASKS - 1);
   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign cur_idx   = cur_ff.idx[IDX_W-1:0];

   always_comb begin
      state_in       = state_ff;
      cur_in         = cur_ff;
      walk_in        = walk_ff;
      hung_found_in  = hung_found_ff;
      hung_idx_in    = hung_idx_ff;
      hung_beat_in   = hung_beat_ff;
      res_status_in  = res_status_ff;
      check_total_in = check_total_ff;
      feed_total_in  = feed_total_ff;
      fault_total_in = fault_total_ff;
      reg_in         = reg_ff;
      live_in        = live_ff;
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_data_in    = out_data_ff;
      q_pop          = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = cur_idx;
      mem_raddr      = cur_idx;
      mem_wdata      = '0;

      case (state_ff)
         thm_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop         = 1'b1;
               cur_in        = q_item;
               res_status_in = thm_pkg::STAT_OK;
               hung_found_in = 1'b0;
               hung_idx_in   = '0;
               hung_beat_in  = '0;
               state_in      = thm_pkg::ST_RESP;
               case (q_item.op)
                  thm_pkg::OP_REGISTER: begin
                     if (q_item.id_ok) begin
                        mem_we    = 1'b1;
                        mem_waddr = q_item.idx[IDX_W-1:0];
                        reg_in[q_item.idx[IDX_W-1:0]] = 1'b1;
                     end else begin
                        res_status_in = thm_pkg::STAT_BAD_ID;
                     end
                  end
                  thm_pkg::OP_BEAT: begin
                     if (q_item.id_ok) begin
                        mem_raddr = q_item.idx[IDX_W-1:0];
                        state_in  = thm_pkg::ST_BEAT;
                     end
                  end
                  thm_pkg::OP_CHECK: begin
                     check_total_in = check_total_ff + thm_pkg::TOTAL_W'(1);
                     mem_raddr      = '0;
                     walk_in        = '0;
                     state_in       = thm_pkg::ST_WALK;
                  end
                  default: ;
               endcase
            end
         end
         thm_pkg::ST_BEAT: begin
            mem_we         = 1'b1;
            mem_wdata      = rec_cur;
            mem_wdata.beat = rec_cur.beat + thm_pkg::BEAT_W'(1);
            state_in       = thm_pkg::ST_RESP;
         end
         thm_pkg::ST_WALK: begin
            // read of the next slot overlaps the update of this one
            mem_raddr = walk_last ? '0 : walk_ff + IDX_W'(1);
            if (reg_ff[walk_ff]) begin
               mem_we           = 1'b1;
               mem_waddr        = walk_ff;
               mem_wdata.beat   = rec_cur.beat;
               mem_wdata.seen   = rec_cur.beat;
               mem_wdata.missed = miss_next;
               if (beat_same && miss_next >= max_missed) begin
                  hung_found_in = 1'b1;
                  hung_idx_in   = walk_ff;
                  hung_beat_in  = rec_cur.beat;
               end
            end
            if (walk_last) state_in = thm_pkg::ST_DECIDE;
            else walk_in = walk_ff + IDX_W'(1);
         end
         thm_pkg::ST_DECIDE: begin
            if (hung_found_ff) begin
               fault_total_in      = fault_total_ff + thm_pkg::TOTAL_W'(1);
               reg_in[hung_idx_ff] = 1'b0;
               res_status_in       = thm_pkg::STAT_HUNG;
            end else begin
               feed_total_in = feed_total_ff + thm_pkg::TOTAL_W'(1);
            end
            state_in = thm_pkg::ST_RESP;
         end
         thm_pkg::ST_RESP: begin
            if (out_free) begin
               out_valid_in               = 1'b1;
               out_data_in.status         = res_status_ff;
               out_data_in.feed           = (cur_ff.op == thm_pkg::OP_CHECK) && !hung_found_ff;
               out_data_in.hung_slot      = thm_pkg::TASK_IDX_W'(hung_idx_ff);
               out_data_in.hung_heartbeat = hung_beat_ff;
               out_data_in.health_checks  = check_total_ff;
               out_data_in.feeds_total    = feed_total_ff;
               out_data_in.faults_total   = fault_total_ff;
               state_in                   = thm_pkg::ST_IDLE;
            end
         end
         default: state_in = thm_pkg::ST_IDLE;
      endcase

      if (mem_we) live_in[mem_waddr] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= thm_pkg::ST_IDLE;
         hung_found_ff  <= 1'b0;
         check_total_ff <= '0;
         feed_total_ff  <= '0;
         fault_total_ff <= '0;
         reg_ff         <= '0;
         live_ff        <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         hung_found_ff  <= hung_found_in;
         check_total_ff <= check_total_in;
         feed_total_ff  <= feed_total_in;
         fault_total_ff <= fault_total_in;
         reg_ff         <= reg_in;
         live_ff        <= live_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      walk_ff       <= walk_in;
      hung_idx_ff   <= hung_idx_in;
      hung_beat_ff  <= hung_beat_in;
      res_status_ff <= res_status_in;
      out_data_ff   <= out_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= mem[mem_raddr];
      rd_live_ff <= live_ff[mem_raddr];
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.status         = out_data_ff.status;
   assign rsp_chan.feed           = out_data_ff.feed;
   assign rsp_chan.hung_slot      = out_data_ff.hung_slot;
   assign rsp_chan.hung_heartbeat = out_data_ff.hung_heartbeat;
   assign rsp_chan.health_checks  = out_data_ff.health_checks;
   assign rsp_chan.feeds_total    = out_data_ff.feeds_total;
   assign rsp_chan.faults_total   = out_data_ff.faults_total;

   a_feed_counted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == thm_pkg::ST_DECIDE && !hung_found_ff)
         |=> feed_total_ff == $past(feed_total_ff) + thm_pkg::TOTAL_W'(1))
      else $error("feed total not advanced after a clean check");

   a_hung_dropped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == thm_pkg::ST_DECIDE && hung_found_ff) |=> !reg_ff[hung_idx_ff])
      else $error("hung task still registered");

   a_out_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff) == thm_pkg::ST_RESP)
      else $error("response loaded outside the response step");

   a_hung_no_feed: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_data_ff.status == thm_pkg::STAT_HUNG)
         |-> !out_data_ff.feed && out_data_ff.faults_total != '0)
      else $error("hung report carries a feed");

endmodule

### rtl/core/task_heartbeat_monitor.sv
// top level of the task heartbeat monitor
//
// req_chan carries one item per request: req_type selects register task,
// heartbeat or health check, task_id names the task slot. rsp_chan returns
// exactly one item per request, in order, with status, feed flag, hung task
// report and the wrapping check, feed and fault totals.
// csr_we/csr_wdata write max_missed, the number of missed checks in a row
// that declares a task hung; write it only while no request is in flight.
// Requests enter a two-deep command queue; a sequencer drains it one item at
// a time against a per-task table held in a single-port-write memory.
// Steps per item from queue head to response register: register and unused
// codes go straight to the response step, heartbeat reads then writes back,
// health check walks the task slots, one task slot per cycle, then decides.
// Reset clears the queue, task registrations and totals and sets the threshold to 3;
// the table needs no clearing pass. A stalled response holds in its output
// register while the sequencer finishes the next item, and the queue keeps
// accepting until full.
`timescale 1ns / 1ps
module task_heartbeat_monitor #(
   parameter int NUM_TASKS = thm_pkg::DEF_NUM_TASKS
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [7:0] csr_wdata,
   thm_req_if.sink    req_chan,
   thm_rsp_if.source  rsp_chan
);

   logic [thm_pkg::MISS_W-1:0] max_missed_ff, max_missed_in;
   logic             q_push, q_full, q_pop, q_valid;
   thm_pkg::cmd_type push_item, head_item;

   assign max_missed_in = csr_we ? csr_wdata : max_missed_ff;

   always_ff @(posedge clock) begin
      if (reset) max_missed_ff <= thm_pkg::MAX_MISSED_RST;
      else max_missed_ff <= max_missed_in;
   end

   thm_front #(.NUM_TASKS(NUM_TASKS)) u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_item   (push_item)
   );

   thm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_item  (push_item),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (head_item)
   );

   thm_back #(.NUM_TASKS(NUM_TASKS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .max_missed (max_missed_ff),
      .q_valid    (q_valid),
      .q_item     (head_item),
      .q_pop      (q_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule
